// ----- hdl/pia_pkg.sv -----
// Package: types, constants and control structs shared by the packed item array.
`timescale 1ns / 1ps
`default_nettype none
package pia_pkg;

  localparam int unsigned MEM_WORDS_DEF = 1024;
  localparam int unsigned WORD_BITS_DEF = 64;

  localparam int unsigned POS_W = 17;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CFG_W = 6;

  localparam logic [CFG_W-1:0] ITEM_WIDTH_RST = 6'd5;
  localparam logic [CFG_W-1:0] ITEM_WIDTH_MAX = 6'd32;
  localparam logic [CFG_W-1:0] ITEM_WIDTH_MIN = 6'd1;
  localparam logic [POS_W-1:0] COUNT_MAX      = 17'h1FFFF;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_APPEND = 2'd2;
  localparam logic [1:0] MODE_EXTEND = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADCOUNT = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [1:0]       status;
    logic [POS_W-1:0] item_count;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic div_start;
    logic div_sel_w;
    logic ipw_load;
    logic cap_load;
    logic addr_load;
    logic mem_rd;
    logic modify;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic early;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/packed_item_array.sv -----
// Top level: items of configurable width packed into memory words.
// A refused request or an extend takes one 17-step pass of the serial divider; read, write and append
// take a second pass for word index and bit offset, then a RAM read and a modify step.
// A new request is taken in the cycle the result strobe is shown.
// After reset the store is cleared one word a cycle, with busy high.
// The receiver cannot stall: done_o is high for exactly one cycle per request.
`timescale 1ns / 1ps
`default_nettype none
module packed_item_array import pia_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             req_i,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  output rsp_t                  rsp_o,
  output logic                  done_o
);

  cmd_t cmd;
  sts_t sts;

  pia_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  pia_datapath #(
    .MEM_WORDS (MEM_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o),
    .done_o      (done_o)
  );

endmodule
`default_nettype wire

// ----- hdl/pia_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pia_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/pia_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pia_div import pia_pkg::*; #(
  parameter int unsigned DVS_W = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [POS_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [POS_W-1:0] quotient_o,
  output logic      [DVS_W-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(POS_W + 1);

  logic [POS_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, dvd_q[POS_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(POS_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[POS_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

// ----- hdl/pia_datapath.sv -----
// Datapath: width register, count, range checks, divider, packed word store, result register.
`timescale 1ns / 1ps
`default_nettype none
module pia_datapath import pia_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire req_t             req_i,
  input  wire cmd_t             cmd_i,
  output sts_t                  sts_o,
  output rsp_t                  rsp_o,
  output logic                  done_o
);

  localparam int unsigned AW     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned IPW_W  = $clog2(WORD_BITS + 1);
  localparam int unsigned SHW    = $clog2(WORD_BITS);
  localparam int unsigned PROD_W = POS_W + IPW_W;
  localparam int unsigned SHP_W  = IPW_W + CFG_W;

  logic [CFG_W-1:0]     width_q;
  logic [POS_W-1:0]     count_q;
  logic [POS_W-1:0]     count_d;
  req_t                 req_q;
  logic [IPW_W-1:0]     ipw_q;
  logic [POS_W-1:0]     cap_q;
  logic [POS_W-1:0]     cap_d;
  logic [AW-1:0]        idx_q;
  logic [SHW-1:0]       sh_q;
  logic [AW-1:0]        clr_q;
  rsp_t                 rsp_q;
  logic                 done_q;

  logic [CFG_W-1:0]     w_eff;
  logic [1:0]           st;
  logic [PROD_W-1:0]    prod;
  logic [POS_W-1:0]     div_dividend;
  logic [IPW_W-1:0]     div_divisor;
  logic                 div_done;
  logic [POS_W-1:0]     div_quot;
  logic [IPW_W-1:0]     div_rem;
  logic [SHP_W-1:0]     sh_prod;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] shifted;
  logic [WORD_BITS-1:0] new_word;
  logic [VAL_W-1:0]     item_val;
  logic                 wr_ok;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;

  always_comb begin
    if (width_q == '0) begin
      w_eff = ITEM_WIDTH_MIN;
    end else if (width_q > ITEM_WIDTH_MAX) begin
      w_eff = ITEM_WIDTH_MAX;
    end else begin
      w_eff = width_q;
    end
  end

  // check request against count and capacity
  always_comb begin
    case (req_q.mode)
      MODE_READ, MODE_WRITE: begin
        st = (req_q.position >= count_q || req_q.position >= cap_q) ? ST_RANGE : ST_OK;
      end
      MODE_APPEND: begin
        st = (count_q >= cap_q) ? ST_FULL : ST_OK;
      end
      MODE_EXTEND: begin
        st = (req_q.position <= count_q || req_q.position > cap_q) ? ST_BADCOUNT : ST_OK;
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (st == ST_OK && req_q.mode == MODE_APPEND) begin
      count_d = count_q + POS_W'(1);
    end else if (st == ST_OK && req_q.mode == MODE_EXTEND) begin
      count_d = req_q.position;
    end
  end

  assign sts_o.early      = (st != ST_OK) || (req_q.mode == MODE_EXTEND);
  assign sts_o.div_done   = div_done;
  assign sts_o.clear_last = (clr_q == AW'(MEM_WORDS - 1));

  assign div_dividend = cmd_i.div_sel_w ? POS_W'(WORD_BITS) :
                        ((req_q.mode == MODE_APPEND) ? count_q : req_q.position);
  assign div_divisor  = cmd_i.div_sel_w ? IPW_W'(w_eff) : ipw_q;

  pia_div #(
    .DVS_W (IPW_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign prod    = PROD_W'(MEM_WORDS) * PROD_W'(ipw_q);
  assign cap_d   = (prod > PROD_W'(COUNT_MAX)) ? COUNT_MAX : prod[POS_W-1:0];
  assign sh_prod = SHP_W'(div_rem) * SHP_W'(w_eff);

  assign mask     = (WORD_BITS'(1) << w_eff) - WORD_BITS'(1);
  assign shifted  = (rdata >> sh_q) & mask;
  assign item_val = shifted[VAL_W-1:0];
  assign new_word = (rdata & ~(mask << sh_q)) |
                    ((WORD_BITS'(req_q.write_value) & mask) << sh_q);

  assign wr_ok     = (st == ST_OK) &&
                     (req_q.mode == MODE_WRITE || req_q.mode == MODE_APPEND);
  assign ram_we    = cmd_i.clear || (cmd_i.modify && wr_ok);
  assign ram_waddr = cmd_i.clear ? clr_q : idx_q;
  assign ram_wdata = cmd_i.clear ? '0 : new_word;

  pia_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= ITEM_WIDTH_RST;
      count_q <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (cmd_i.finish) begin
        count_q <= count_d;
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.ipw_load) begin
      ipw_q <= div_quot[IPW_W-1:0];
    end
    if (cmd_i.cap_load) begin
      cap_q <= cap_d;
    end
    if (cmd_i.addr_load) begin
      idx_q <= div_quot[AW-1:0];
      sh_q  <= sh_prod[SHW-1:0];
    end
    if (cmd_i.finish) begin
      rsp_q.read_value <= (req_q.mode == MODE_READ && st == ST_OK) ? item_val : '0;
      rsp_q.status     <= st;
      rsp_q.item_count <= count_d;
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- hdl/pia_ctrl.sv -----
// Controller: sequences clearing pass, divisions, memory access and result.
`timescale 1ns / 1ps
`default_nettype none
module pia_ctrl import pia_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIVW  = 3'd2;
  localparam logic [2:0] S_CAP   = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DIVP  = 3'd5;
  localparam logic [2:0] S_RD    = 3'd6;
  localparam logic [2:0] S_MOD   = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load      = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_w = 1'b1;
          state_d         = S_DIVW;
        end
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.ipw_load = 1'b1;
          state_d        = S_CAP;
        end
      end
      S_CAP: begin
        cmd_o.cap_load = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.early) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVP;
        end
      end
      S_DIVP: begin
        if (sts_i.div_done) begin
          cmd_o.addr_load = 1'b1;
          state_d         = S_RD;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_MOD;
      end
      S_MOD: begin
        cmd_o.modify = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ----- hdl/pia_checker.sv -----
// Port checker for the packed item array, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pia_checker import pia_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire req_t             req_i,
  input wire logic             cfg_we_i,
  input wire logic [CFG_W-1:0] cfg_wdata_i,
  input wire rsp_t             rsp_o,
  input wire logic             done_o
);

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.read_value == '0))
    else $error("refused request returned non-zero read value");

  a_no_done_without_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !done_o) |=> !done_o)
    else $error("result without a request in flight");

endmodule

bind packed_item_array pia_checker u_pia_checker (.*);
`default_nettype wire

// ----- verif/packed_item_array_test.sv -----
// Self-checking testbench for packed_item_array: directed table, then random requests.
`timescale 1ns / 1ps
module packed_item_array_test import pia_pkg::*;;

  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 95;
  localparam int unsigned DRAIN_CYCLES    = 50;
  localparam int unsigned N_PROBES        = 22;
  localparam int unsigned N_PHASES        = 16;

  typedef struct packed {
    logic [1:0]       mode;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             typed;
    logic [VAL_W-1:0] rd;
    logic [1:0]       st;
    logic [POS_W-1:0] cnt;
  } probe_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [6:0]       idle_pct;
    logic             fill;
  } phase_t;

  // width 5 after reset: 12 items per word, capacity 12288
  localparam probe_t PROBES [N_PROBES] = '{
    '{MODE_READ,   17'd0,     32'h0,        1'b1, 32'h0,  ST_RANGE,    17'd0},
    '{MODE_WRITE,  17'd0,     32'hFFFFFFFF, 1'b1, 32'h0,  ST_RANGE,    17'd0},
    '{MODE_EXTEND, 17'd0,     32'h0,        1'b1, 32'h0,  ST_BADCOUNT, 17'd0},
    '{MODE_APPEND, 17'd0,     32'hFFFFFFFF, 1'b1, 32'h0,  ST_OK,       17'd1},
    '{MODE_READ,   17'd0,     32'h0,        1'b1, 32'h1F, ST_OK,       17'd1},
    '{MODE_APPEND, 17'd0,     32'h12345,    1'b1, 32'h0,  ST_OK,       17'd2},
    '{MODE_READ,   17'd1,     32'h0,        1'b0, 32'h0,  ST_OK,       17'd0},
    '{MODE_WRITE,  17'd1,     32'h0,        1'b1, 32'h0,  ST_OK,       17'd2},
    '{MODE_READ,   17'd1,     32'h0,        1'b1, 32'h0,  ST_OK,       17'd2},
    '{MODE_READ,   17'd2,     32'h0,        1'b1, 32'h0,  ST_RANGE,    17'd2},
    '{MODE_EXTEND, 17'h1FFFF, 32'h0,        1'b1, 32'h0,  ST_BADCOUNT, 17'd2},
    '{MODE_READ,   17'h1FFFF, 32'h0,        1'b1, 32'h0,  ST_RANGE,    17'd2},
    '{MODE_EXTEND, 17'd13,    32'h0,        1'b1, 32'h0,  ST_OK,       17'd13},
    '{MODE_WRITE,  17'd11,    32'h15,       1'b1, 32'h0,  ST_OK,       17'd13},
    '{MODE_WRITE,  17'd12,    32'h1E,       1'b1, 32'h0,  ST_OK,       17'd13},
    '{MODE_READ,   17'd11,    32'h0,        1'b1, 32'h15, ST_OK,       17'd13},
    '{MODE_READ,   17'd12,    32'h0,        1'b1, 32'h1E, ST_OK,       17'd13},
    '{MODE_EXTEND, 17'd13,    32'h0,        1'b1, 32'h0,  ST_BADCOUNT, 17'd13},
    '{MODE_EXTEND, 17'd12289, 32'h0,        1'b1, 32'h0,  ST_BADCOUNT, 17'd13},
    '{MODE_APPEND, 17'd0,     32'hFFFFFFE0, 1'b1, 32'h0,  ST_OK,       17'd14},
    '{MODE_READ,   17'd13,    32'h0,        1'b1, 32'h0,  ST_OK,       17'd14},
    '{MODE_WRITE,  17'd14,    32'h0,        1'b1, 32'h0,  ST_RANGE,    17'd14}
  };

  // after the first phase, capacity never shrinks until the last phase, so the count stays usable
  localparam phase_t PHASES [N_PHASES] = '{
    '{6'd32, 7'd0,  1'b0}, '{6'd63, 7'd56, 1'b0}, '{6'd40, 7'd23, 1'b0},
    '{6'd27, 7'd0,  1'b1}, '{6'd21, 7'd56, 1'b0}, '{6'd16, 7'd23, 1'b0},
    '{6'd12, 7'd0,  1'b0}, '{6'd10, 7'd56, 1'b0}, '{6'd8,  7'd23, 1'b1},
    '{6'd6,  7'd0,  1'b0}, '{6'd4,  7'd56, 1'b0}, '{6'd3,  7'd23, 1'b0},
    '{6'd2,  7'd0,  1'b0}, '{6'd0,  7'd56, 1'b0}, '{6'd1,  7'd23, 1'b1},
    '{6'd32, 7'd0,  1'b0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req_i;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  rsp_t             rsp_o;
  logic             done_o;

  logic [WORD_BITS_DEF-1:0] shadow_words [MEM_WORDS_DEF];
  int unsigned              shadow_count;
  logic [CFG_W-1:0]         shadow_width;
  rsp_t                     expected_rsp [$];
  int unsigned              mismatches;
  int unsigned              idle_cycles;

  packed_item_array dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .rsp_o,
    .done_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_bits(input logic [CFG_W-1:0] w);
    if (w == '0) return 1;
    if (w > ITEM_WIDTH_MAX) return 32;
    return 32'(w);
  endfunction

  function automatic int unsigned capacity_of(input logic [CFG_W-1:0] w);
    int unsigned c;
    c = MEM_WORDS_DEF * (WORD_BITS_DEF / eff_bits(w));
    if (c > 32'(COUNT_MAX)) c = 32'(COUNT_MAX);
    return c;
  endfunction

  function automatic rsp_t predict_access(input req_t r);
    int unsigned              w;
    int unsigned              ipw;
    int unsigned              cap;
    int unsigned              pos;
    int unsigned              idx;
    int unsigned              sh;
    logic [WORD_BITS_DEF-1:0] m;
    bit                       do_put;
    rsp_t                     o;
    w      = eff_bits(shadow_width);
    ipw    = WORD_BITS_DEF / w;
    cap    = capacity_of(shadow_width);
    m      = (64'd1 << w) - 64'd1;
    o      = '0;
    o.status = ST_OK;
    do_put = 1'b0;
    pos    = 32'(r.position);
    case (r.mode)
      MODE_READ, MODE_WRITE: begin
        if (pos >= shadow_count || pos >= cap) begin
          o.status = ST_RANGE;
        end else if (r.mode == MODE_READ) begin
          o.read_value = VAL_W'((shadow_words[pos / ipw] >> ((pos % ipw) * w)) & m);
        end else begin
          do_put = 1'b1;
        end
      end
      MODE_APPEND: begin
        if (shadow_count >= cap) begin
          o.status = ST_FULL;
        end else begin
          do_put = 1'b1;
          pos    = shadow_count;
          shadow_count++;
        end
      end
      default: begin
        if (pos <= shadow_count || pos > cap) o.status = ST_BADCOUNT;
        else shadow_count = pos;
      end
    endcase
    if (do_put) begin
      idx = pos / ipw;
      sh  = (pos % ipw) * w;
      shadow_words[idx] = (shadow_words[idx] & ~(m << sh))
                        | ((64'(r.write_value) & m) << sh);
    end
    o.item_count = POS_W'(shadow_count);
    return o;
  endfunction

  function automatic void note_mismatch(input string what, input longint unsigned want,
                                        input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
  endfunction

  // typed_rsp replaces the prediction on rows whose result is written in the table
  task automatic issue(input req_t r, input bit typed, input rsp_t typed_rsp,
                       input int unsigned gap);
    rsp_t want;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = predict_access(r);
    if (typed) want = typed_rsp;
    expected_rsp.push_back(want);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic set_width(input logic [CFG_W-1:0] w);
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    shadow_width  = w;
  endtask

  // results are sampled mid-cycle, away from the edge that moves them
  always @(negedge clk_i) begin : check_rsp
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        note_mismatch("unexpected result", 64'(0), 64'(rsp_o));
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_o.read_value !== want.read_value)
          note_mismatch("read_value", 64'(want.read_value), 64'(rsp_o.read_value));
        if (rsp_o.status !== want.status)
          note_mismatch("status", 64'(want.status), 64'(rsp_o.status));
        if (rsp_o.item_count !== want.item_count)
          note_mismatch("item_count", 64'(want.item_count), 64'(rsp_o.item_count));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    req_t        r;
    rsp_t        pinned;
    int unsigned gap;
    int unsigned cap;
    int unsigned sel;
    int unsigned span;
    int unsigned k;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    shadow_count = 0;
    shadow_width = ITEM_WIDTH_RST;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_PROBES; i++) begin
      r.mode              = PROBES[i].mode;
      r.position          = PROBES[i].pos;
      r.write_value       = PROBES[i].val;
      pinned.read_value   = PROBES[i].rd;
      pinned.status       = PROBES[i].st;
      pinned.item_count   = PROBES[i].cnt;
      issue(r, PROBES[i].typed, pinned, (i == N_PROBES - 1) ? 1 : 0);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_width(PHASES[p].width);
      for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
        cap = capacity_of(shadow_width);
        sel = $urandom_range(99);
        k   = $urandom_range(9);
        if (k == 0) r.write_value = '0;
        else if (k == 1) r.write_value = '1;
        else r.write_value = $urandom;
        r.position = POS_W'($urandom_range(COUNT_MAX));
        if (sel < 60) begin
          r.mode = (sel < 35) ? MODE_READ : MODE_WRITE;
          if (shadow_count != 0 && $urandom_range(6) != 0) begin
            if ($urandom_range(1) == 1) begin
              r.position = POS_W'($urandom_range(shadow_count - 1));
            end else begin
              span = (shadow_count - 1 < 15) ? shadow_count - 1 : 15;
              r.position = POS_W'(shadow_count - 1 - $urandom_range(span));
            end
          end
        end else if (sel < 85) begin
          r.mode = MODE_APPEND;
        end else begin
          r.mode = MODE_EXTEND;
          if (k < 7) r.position = POS_W'(shadow_count + $urandom_range(4, 1));
          else if (k < 8) r.position = POS_W'($urandom_range(shadow_count));
        end
        gap = ($urandom_range(99) < PHASES[p].idle_pct) ? $urandom_range(50, 1) : 0;
        if (j == ITEMS_PER_PHASE - 1 && gap == 0) gap = 1;
        issue(r, 1'b0, '0, gap);
      end
      if (PHASES[p].fill) begin
        // run up to capacity, then hit the full and range edges
        cap = capacity_of(shadow_width);
        r.write_value = $urandom;
        r.mode = MODE_EXTEND;
        r.position = POS_W'(cap);
        issue(r, 1'b0, '0, 0);
        r.mode = MODE_APPEND;
        issue(r, 1'b0, '0, 0);
        r.mode = MODE_WRITE;
        r.position = POS_W'(cap - 1);
        issue(r, 1'b0, '0, 0);
        r.mode = MODE_READ;
        issue(r, 1'b0, '0, 0);
        r.position = POS_W'(cap);
        issue(r, 1'b0, '0, 1);
      end
    end

    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
